// File: rtl/core/bsbb_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and trig step tables for the bend swept box block
// no dependencies
package bsbb_pkg;

	localparam int CNT_W = 6;
	localparam int DVD_W = 24;
	localparam int EXT_W = 34;
	localparam int MAX_INTERVALS_DEF = 31;
	localparam int TRIG_STEPS = 4;

	localparam logic [30:0] MIN_EXTENT_RST = 31'd327680;
	localparam logic [30:0] LONG_LIMIT_RST = 31'd6553600;
	localparam logic [4:0] SHORT_CNT_RST = 5'd10;
	localparam logic [4:0] LONG_CNT_RST = 5'd20;
	localparam logic [15:0] MIN_COS_RST = 16'd6554;

	localparam logic [22:0] HALF_TURN = 23'd4608000;
	localparam logic [21:0] QUARTER_TURN = 22'd2304000;
	localparam logic [21:0] EIGHTH_TURN = 22'd1152000;
	localparam logic [25:0] RAD_SCALE = 26'd47975245;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	typedef enum logic [2:0] {
		REG_MIN_EXTENT = 3'd0,
		REG_LONG_LIMIT = 3'd1,
		REG_SHORT_CNT = 3'd2,
		REG_LONG_CNT = 3'd3,
		REG_MIN_COS = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;
	typedef enum logic [1:0] {B_IDLE, B_SWEPT, B_ANGLE, B_DRAIN} back_state_t;

	typedef struct packed {
		logic [15:0] bend_id;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [30:0] flange_length;
		logic signed [15:0] bend_angle;
	} in_t;

	typedef struct packed {
		logic [15:0] bend_tag;
		logic box_kind;
		logic [4:0] interval_index;
		logic signed [31:0] min_x;
		logic signed [31:0] min_y;
		logic signed [31:0] min_z;
		logic signed [31:0] max_x;
		logic signed [31:0] max_y;
		logic signed [31:0] max_z;
		logic last_box;
	} out_t;

	typedef struct packed {
		logic [30:0] min_extent;
		logic [30:0] long_limit;
		logic [4:0] short_cnt;
		logic [4:0] long_cnt;
		logic [15:0] min_cos;
	} cfg_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [2:0][31:0] pos;
		logic [2:0][15:0] dm;
		logic [2:0][15:0] nm;
		logic [30:0] len;
		logic [2:0][EXT_W-1:0] swept;
		logic [CNT_W-1:0] cnt;
		logic [DVD_W-1:0] quo;
		logic [CNT_W-1:0] rem;
	} desc_t;

	typedef struct packed {
		logic kind;
		logic [CNT_W-1:0] idx;
		logic last;
	} tok_t;

	// reciprocal of the sine series divisors 72, 42, 20, 6
	function automatic logic [31:0] sin_magic(input int j);
		case (j)
			0: sin_magic = 32'd3817748708;
			1: sin_magic = 32'd3272356036;
			2: sin_magic = 32'd3435973837;
			default: sin_magic = 32'd2863311531;
		endcase
	endfunction

	function automatic int sin_shift(input int j);
		case (j)
			0: sin_shift = 38;
			1: sin_shift = 37;
			2: sin_shift = 36;
			default: sin_shift = 34;
		endcase
	endfunction

	// reciprocal of the cosine series divisors 90, 56, 30, 12
	function automatic logic [31:0] cos_magic(input int j);
		case (j)
			0: cos_magic = 32'd3054198967;
			1: cos_magic = 32'd2454267027;
			2: cos_magic = 32'd2290649225;
			default: cos_magic = 32'd2863311531;
		endcase
	endfunction

	function automatic int cos_shift(input int j);
		case (j)
			0: cos_shift = 38;
			1: cos_shift = 37;
			2: cos_shift = 36;
			default: cos_shift = 35;
		endcase
	endfunction

endpackage

// File: rtl/core/bsbb_front.sv
`timescale 1ns / 1ps
// front end: takes a bend, picks the interval count, divides the angle span
// by it one bit a cycle and forms the swept box extents; uses bsbb_pkg
module bsbb_front #(
	parameter int MAX_INTERVALS = bsbb_pkg::MAX_INTERVALS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input bsbb_pkg::in_t item,
	input bsbb_pkg::cfg_t cfg,
	output logic push,
	input logic full,
	output bsbb_pkg::desc_t desc
);

	localparam int CNT_W = bsbb_pkg::CNT_W;
	localparam int DVD_W = bsbb_pkg::DVD_W;
	localparam int EXT_W = bsbb_pkg::EXT_W;
	localparam int ITC_W = $clog2(DVD_W);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_INTERVALS);

	bsbb_pkg::front_state_t st_q, st_nx;
	bsbb_pkg::desc_t desc_q;
	logic [DVD_W-1:0] dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [ITC_W-1:0] itc_q;
	logic [2:0][17:0] g_q;

	logic accept;
	logic [15:0] ang_mag;
	logic [2:0][15:0] d_mag, n_mag;
	logic [2:0][14:0] off;
	logic [2:0][17:0] g_in;
	logic [CNT_W-1:0] cnt_sel, cnt_use;
	logic [CNT_W:0] trial;
	logic ge;

	function automatic logic [15:0] mag16(input logic [15:0] v);
		mag16 = v[15] ? 16'(~v + 16'd1) : v;
	endfunction

	assign accept = start && (st_q == bsbb_pkg::F_IDLE);

	always_comb begin
		ang_mag = mag16(item.bend_angle);
		d_mag[0] = mag16(item.dir_x);
		d_mag[1] = mag16(item.dir_y);
		d_mag[2] = mag16(item.dir_z);
		n_mag[0] = mag16(item.norm_x);
		n_mag[1] = mag16(item.norm_y);
		n_mag[2] = mag16(item.norm_z);
		for (int k = 0; k < 3; k++) begin
			off[k] = (d_mag[k] > 16'd16384) ? 15'(d_mag[k] - 16'd16384)
				: 15'(16'd16384 - d_mag[k]);
			g_in[k] = 18'(d_mag[k]) + ((18'(n_mag[k]) + 18'(off[k])) << 1);
		end
		cnt_sel = (item.flange_length < cfg.long_limit) ? CNT_W'(cfg.short_cnt)
			: CNT_W'(cfg.long_cnt);
		priority if (cnt_sel == '0) begin
			cnt_use = CNT_W'(1);
		end else if (cnt_sel > CNT_MAX) begin
			cnt_use = CNT_MAX;
		end else begin
			cnt_use = cnt_sel;
		end
	end

	// restoring divider, one quotient bit a cycle
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge = trial >= {1'b0, desc_q.cnt};

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			bsbb_pkg::F_IDLE: if (start) st_nx = bsbb_pkg::F_DIV;
			bsbb_pkg::F_DIV: if (itc_q == ITC_W'(DVD_W - 1)) st_nx = bsbb_pkg::F_PUSH;
			bsbb_pkg::F_PUSH: if (!full) st_nx = bsbb_pkg::F_IDLE;
			default: st_nx = bsbb_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		busy = (st_q != bsbb_pkg::F_IDLE);
		push = (st_q == bsbb_pkg::F_PUSH) && !full;
		desc = desc_q;
		desc.quo = dvd_q;
		desc.rem = rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= bsbb_pkg::F_IDLE;
			itc_q <= '0;
		end else begin
			st_q <= st_nx;
			if (accept) itc_q <= '0;
			else if (st_q == bsbb_pkg::F_DIV) itc_q <= itc_q + ITC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_q.tag <= item.bend_id;
			desc_q.pos[0] <= item.pos_x;
			desc_q.pos[1] <= item.pos_y;
			desc_q.pos[2] <= item.pos_z;
			desc_q.dm <= d_mag;
			desc_q.nm <= n_mag;
			desc_q.len <= item.flange_length;
			desc_q.cnt <= cnt_use;
			desc_q.quo <= '0;
			desc_q.rem <= '0;
			g_q <= g_in;
			dvd_q <= {ang_mag, 8'd0};
			rem_q <= '0;
		end else if (st_q == bsbb_pkg::F_DIV) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= ge ? CNT_W'(trial - {1'b0, desc_q.cnt}) : CNT_W'(trial);
			for (int k = 0; k < 3; k++) begin
				desc_q.swept[k] <= EXT_W'((49'(desc_q.len) * 49'(g_q[k])) >> 15);
			end
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && st_q == bsbb_pkg::F_DIV)
		else $error("front did not start dividing");
	a_push_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> $past(st_q) == bsbb_pkg::F_DIV || $past(st_q) == bsbb_pkg::F_PUSH)
		else $error("push without finished division");
	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == bsbb_pkg::F_DIV && itc_q != ITC_W'(DVD_W - 1) |=> st_q == bsbb_pkg::F_DIV)
		else $error("division left early");

endmodule

// File: rtl/core/bsbb_fifo.sv
`timescale 1ns / 1ps
// two-entry queue of bend descriptors between front and back
// uses bsbb_pkg
module bsbb_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input bsbb_pkg::desc_t wdata,
	output logic full,
	output logic empty,
	input logic pop,
	output bsbb_pkg::desc_t rdata
);

	localparam int DEPTH = 2;
	localparam int AW = 1;

	bsbb_pkg::desc_t mem_q [0:DEPTH-1];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	assign full = (cnt_q == (AW + 1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + AW'(1);
			if (pop) rp_q <= rp_q + AW'(1);
			cnt_q <= cnt_q + (AW + 1)'(push) - (AW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

endmodule

// File: rtl/core/bsbb_trig.sv
`timescale 1ns / 1ps
// pipelined |sin| and |cos| in Q16 from an angle in 1/25600 degree
// octant fold, then Taylor series in Q30; uses bsbb_pkg
module bsbb_trig (
	input logic clk,
	input logic arst_n,
	input logic v_in,
	input bsbb_pkg::tok_t tok_in,
	input logic [bsbb_pkg::DVD_W-1:0] t_in,
	output logic v_out,
	output bsbb_pkg::tok_t tok_out,
	output logic [16:0] sin_mag,
	output logic [16:0] cos_mag,
	output logic busy
);

	localparam int STEPS = bsbb_pkg::TRIG_STEPS;
	localparam int LANES = 2 * STEPS + 1;
	localparam logic [30:0] ONE = bsbb_pkg::Q30_ONE;

	typedef struct packed {
		logic v;
		bsbb_pkg::tok_t tok;
		logic swap;
		logic [29:0] x;
		logic [29:0] x2;
	} lane_t;

	logic v_s1, v_s2, v_s3;
	bsbb_pkg::tok_t tok_s1, tok_s2, tok_s3;
	logic sw_s2, sw_s3;
	logic [22:0] t_s1;
	logic [20:0] t_s2;
	logic [29:0] x_s3;
	lane_t lane_q [0:LANES-1];
	logic [30:0] sp_q [0:STEPS-1];
	logic [30:0] cp_q [0:STEPS-1];
	logic [30:0] sa_q [0:STEPS-1];
	logic [30:0] ca_q [0:STEPS-1];
	logic [30:0] sa_in [0:STEPS-1];
	logic [30:0] ca_in [0:STEPS-1];
	lane_t fin_q;
	logic [30:0] s_fin_q, c_fin_q;
	logic [16:0] s_rnd, c_rnd;

	logic [22:0] t_mod;
	logic [21:0] t_half;
	logic sw_fold;
	logic [20:0] t_fold;

	always_comb begin
		t_mod = (t_in >= bsbb_pkg::DVD_W'(bsbb_pkg::HALF_TURN))
			? 23'(t_in - bsbb_pkg::DVD_W'(bsbb_pkg::HALF_TURN)) : 23'(t_in);
		t_half = (t_s1 > 23'(bsbb_pkg::QUARTER_TURN))
			? 22'(bsbb_pkg::HALF_TURN - t_s1) : 22'(t_s1);
		sw_fold = t_half > bsbb_pkg::EIGHTH_TURN;
		t_fold = sw_fold ? 21'(bsbb_pkg::QUARTER_TURN - t_half) : 21'(t_half);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			lane_q[0] <= '0;
			fin_q <= '0;
			v_out <= 1'b0;
		end else begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			lane_q[0].v <= v_s3;
			lane_q[0].tok <= tok_s3;
			lane_q[0].swap <= sw_s3;
			lane_q[0].x <= x_s3;
			lane_q[0].x2 <= 30'((60'(x_s3) * 60'(x_s3)) >> 30);
			fin_q <= lane_q[LANES-1];
			v_out <= fin_q.v;
		end
	end

	always_ff @(posedge clk) begin
		tok_s1 <= tok_in;
		t_s1 <= t_mod;
		tok_s2 <= tok_s1;
		sw_s2 <= sw_fold;
		t_s2 <= t_fold;
		tok_s3 <= tok_s2;
		sw_s3 <= sw_s2;
		x_s3 <= 30'((47'(t_s2) * 47'(bsbb_pkg::RAD_SCALE)) >> 16);
		s_fin_q <= 31'((61'(lane_q[LANES-1].x) * 61'(sa_q[STEPS-1])) >> 30);
		c_fin_q <= ONE - 31'(((61'(lane_q[LANES-1].x2) * 61'(ca_q[STEPS-1])) >> 30) >> 1);
		tok_out <= fin_q.tok;
		sin_mag <= fin_q.swap ? c_rnd : s_rnd;
		cos_mag <= fin_q.swap ? s_rnd : c_rnd;
	end

	assign s_rnd = 17'((32'(s_fin_q) + 32'd8192) >> 14);
	assign c_rnd = 17'((32'(c_fin_q) + 32'd8192) >> 14);

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam logic [31:0] SM = bsbb_pkg::sin_magic(j);
		localparam int SK = bsbb_pkg::sin_shift(j);
		localparam logic [31:0] CM = bsbb_pkg::cos_magic(j);
		localparam int CK = bsbb_pkg::cos_shift(j);

		if (j == 0) begin : g_first
			assign sa_in[j] = ONE;
			assign ca_in[j] = ONE;
		end else begin : g_next
			assign sa_in[j] = sa_q[j-1];
			assign ca_in[j] = ca_q[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lane_q[2*j+1] <= '0;
				lane_q[2*j+2] <= '0;
			end else begin
				lane_q[2*j+1] <= lane_q[2*j];
				lane_q[2*j+2] <= lane_q[2*j+1];
			end
		end

		always_ff @(posedge clk) begin
			sp_q[j] <= 31'((61'(lane_q[2*j].x2) * 61'(sa_in[j])) >> 30);
			cp_q[j] <= 31'((61'(lane_q[2*j].x2) * 61'(ca_in[j])) >> 30);
			sa_q[j] <= ONE - 31'((63'(sp_q[j]) * 63'(SM)) >> SK);
			ca_q[j] <= ONE - 31'((63'(cp_q[j]) * 63'(CM)) >> CK);
		end
	end

	always_comb begin
		busy = v_s1 | v_s2 | v_s3 | fin_q.v | v_out;
		for (int k = 0; k < LANES; k++) begin
			busy = busy | lane_q[k].v;
		end
	end

endmodule

// File: rtl/core/bsbb_back.sv
`timescale 1ns / 1ps
// back end: sequences the swept box and the angle boxes of one bend,
// runs them through the trig pipeline and forms the bounds; uses bsbb_pkg, bsbb_trig
module bsbb_back (
	input logic clk,
	input logic arst_n,
	input bsbb_pkg::cfg_t cfg,
	input logic empty,
	output logic pop,
	input bsbb_pkg::desc_t desc,
	output logic result_valid,
	output bsbb_pkg::out_t result
);

	localparam int CNT_W = bsbb_pkg::CNT_W;
	localparam int DVD_W = bsbb_pkg::DVD_W;
	localparam int EXT_W = bsbb_pkg::EXT_W;

	bsbb_pkg::back_state_t st_q, st_nx;
	bsbb_pkg::desc_t ctx_q;
	logic [CNT_W-1:0] idx_q, r_q;
	logic [DVD_W-1:0] t_q;

	logic iss_v;
	bsbb_pkg::tok_t iss_tok;
	logic [DVD_W-1:0] iss_t;
	logic [CNT_W:0] r_sum;
	logic wrap;

	logic tv, trig_busy, pipe_busy;
	bsbb_pkg::tok_t ttok;
	logic [16:0] s_mag, c_mag;

	logic f1_v, f2_v, f3_v;
	bsbb_pkg::tok_t f1_tok, f2_tok, f3_tok;
	logic [16:0] cf1_q;
	logic [2:0][31:0] sn1_q, w2_q;
	logic [2:0][EXT_W-1:0] ext3_q;
	logic [2:0][EXT_W-1:0] e4;
	logic [2:0][31:0] lo4, hi4;

	function automatic logic [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sd2147483647) sat32 = 32'h7fff_ffff;
		else if (v < -36'sd2147483648) sat32 = 32'h8000_0000;
		else sat32 = v[31:0];
	endfunction

	assign pipe_busy = trig_busy | f1_v | f2_v | f3_v;

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			bsbb_pkg::B_IDLE: if (!empty) st_nx = bsbb_pkg::B_SWEPT;
			bsbb_pkg::B_SWEPT: st_nx = bsbb_pkg::B_ANGLE;
			bsbb_pkg::B_ANGLE: if (idx_q == ctx_q.cnt) st_nx = bsbb_pkg::B_DRAIN;
			bsbb_pkg::B_DRAIN: if (!pipe_busy) st_nx = bsbb_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		iss_v = 1'b0;
		iss_tok = '0;
		iss_t = '0;
		unique case (st_q)
			bsbb_pkg::B_IDLE: pop = !empty;
			bsbb_pkg::B_SWEPT: iss_v = 1'b1;
			bsbb_pkg::B_ANGLE: begin
				iss_v = 1'b1;
				iss_tok.kind = 1'b1;
				iss_tok.idx = idx_q;
				iss_tok.last = (idx_q == ctx_q.cnt);
				iss_t = t_q;
			end
			bsbb_pkg::B_DRAIN: pop = 1'b0;
		endcase
	end

	// next angle: t steps by the quotient, the remainder carries a unit
	assign r_sum = {1'b0, r_q} + {1'b0, ctx_q.rem};
	assign wrap = r_sum >= {1'b0, ctx_q.cnt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= bsbb_pkg::B_IDLE;
			idx_q <= '0;
			r_q <= '0;
			t_q <= '0;
		end else begin
			st_q <= st_nx;
			if (st_q == bsbb_pkg::B_SWEPT) begin
				idx_q <= '0;
				r_q <= '0;
				t_q <= '0;
			end else if (st_q == bsbb_pkg::B_ANGLE) begin
				idx_q <= idx_q + CNT_W'(1);
				r_q <= wrap ? CNT_W'(r_sum - {1'b0, ctx_q.cnt}) : CNT_W'(r_sum);
				t_q <= t_q + ctx_q.quo + DVD_W'(wrap);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) ctx_q <= desc;
	end

	bsbb_trig u_trig (
		.clk(clk),
		.arst_n(arst_n),
		.v_in(iss_v),
		.tok_in(iss_tok),
		.t_in(iss_t),
		.v_out(tv),
		.tok_out(ttok),
		.sin_mag(s_mag),
		.cos_mag(c_mag),
		.busy(trig_busy)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			e4[k] = (ext3_q[k] < EXT_W'(cfg.min_extent)) ? EXT_W'(cfg.min_extent) : ext3_q[k];
			lo4[k] = sat32(36'($signed(ctx_q.pos[k])) - $signed({2'b0, e4[k]}));
			hi4[k] = sat32(36'($signed(ctx_q.pos[k])) + $signed({2'b0, e4[k]}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f1_v <= 1'b0;
			f2_v <= 1'b0;
			f3_v <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			f1_v <= tv;
			f2_v <= f1_v;
			f3_v <= f2_v;
			result_valid <= f3_v;
		end
	end

	always_ff @(posedge clk) begin
		f1_tok <= ttok;
		f2_tok <= f1_tok;
		f3_tok <= f2_tok;
		cf1_q <= (c_mag < 17'(cfg.min_cos)) ? 17'(cfg.min_cos) : c_mag;
		for (int k = 0; k < 3; k++) begin
			sn1_q[k] <= 32'(s_mag) * 32'(ctx_q.nm[k]);
			w2_q[k] <= (32'(ctx_q.dm[k]) << 15) + (32'(cf1_q) << 13) + sn1_q[k];
			ext3_q[k] <= f2_tok.kind ? EXT_W'((64'(ctx_q.len) * 64'(w2_q[k])) >> 30)
				: ctx_q.swept[k];
		end
		result.bend_tag <= ctx_q.tag;
		result.box_kind <= f3_tok.kind;
		result.interval_index <= f3_tok.idx[4:0];
		result.last_box <= f3_tok.last;
		result.min_x <= lo4[0];
		result.min_y <= lo4[1];
		result.min_z <= lo4[2];
		result.max_x <= hi4[0];
		result.max_y <= hi4[1];
		result.max_z <= hi4[2];
	end

	a_swept_then_first: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.box_kind |=> result_valid && result.box_kind
			&& result.interval_index == 5'd0)
		else $error("swept box not followed by first angle box");
	a_angle_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.box_kind && !result.last_box |=> result_valid
			&& result.box_kind)
		else $error("gap inside the angle boxes of a bend");
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_box |=> !result_valid)
		else $error("box right after the last box of a bend");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !pipe_busy && !empty)
		else $error("new bend taken while the pipeline still works");

endmodule

// File: rtl/core/bend_swept_bounding_boxes.sv
`timescale 1ns / 1ps
// top level of the bend swept bounding box block: configuration registers,
// front end, descriptor queue and back end; uses bsbb_pkg and all bsbb_ modules
//
//  channel   handshake                       payload
//  request   start in, busy out              item (bsbb_pkg::in_t)
//  result    result_valid out, one cycle     result (bsbb_pkg::out_t)
//  config    cfg_write in, no wait           cfg_index, cfg_data
//
// the front end works on one bend at a time (one take, 24 divider steps, one
// hand-off); it takes no new request before the hand-off, which waits for room.
// the back end issues the swept box and count + 1 angle boxes of a bend, then
// the 18-stage trig and bounds pipeline drains before the next bend starts.
// reset clears the control state and loads the register defaults; results
// cannot be held off, and the boxes of a bend leave back to back, one per cycle.
module bend_swept_bounding_boxes #(
	parameter int MAX_INTERVALS = bsbb_pkg::MAX_INTERVALS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input bsbb_pkg::in_t item,
	output logic result_valid,
	output bsbb_pkg::out_t result,
	input logic cfg_write,
	input logic [2:0] cfg_index,
	input logic [30:0] cfg_data
);

	bsbb_pkg::cfg_t cfg_q;
	bsbb_pkg::desc_t desc_in, desc_out;
	logic push, pop, full, empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_extent <= bsbb_pkg::MIN_EXTENT_RST;
			cfg_q.long_limit <= bsbb_pkg::LONG_LIMIT_RST;
			cfg_q.short_cnt <= bsbb_pkg::SHORT_CNT_RST;
			cfg_q.long_cnt <= bsbb_pkg::LONG_CNT_RST;
			cfg_q.min_cos <= bsbb_pkg::MIN_COS_RST;
		end else if (cfg_write) begin
			unique case (bsbb_pkg::reg_idx_t'(cfg_index))
				bsbb_pkg::REG_MIN_EXTENT: cfg_q.min_extent <= cfg_data;
				bsbb_pkg::REG_LONG_LIMIT: cfg_q.long_limit <= cfg_data;
				bsbb_pkg::REG_SHORT_CNT: cfg_q.short_cnt <= cfg_data[4:0];
				bsbb_pkg::REG_LONG_CNT: cfg_q.long_cnt <= cfg_data[4:0];
				bsbb_pkg::REG_MIN_COS: cfg_q.min_cos <= cfg_data[15:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	bsbb_front #(
		.MAX_INTERVALS(MAX_INTERVALS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.cfg(cfg_q),
		.push(push),
		.full(full),
		.desc(desc_in)
	);

	bsbb_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(desc_in),
		.full(full),
		.empty(empty),
		.pop(pop),
		.rdata(desc_out)
	);

	bsbb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.empty(empty),
		.pop(pop),
		.desc(desc_out),
		.result_valid(result_valid),
		.result(result)
	);

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench for bend_swept_bounding_boxes: directed and random bends against a
// built-in box predictor; depends on bsbb_pkg and the block's rtl
module testbench;

	localparam logic [63:0] HALF_T = 64'd4608000;
	localparam logic [63:0] QUART_T = 64'd2304000;
	localparam logic [63:0] EIGHTH_T = 64'd1152000;
	localparam logic [63:0] Q30 = 64'd1 << 30;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	bsbb_pkg::in_t item;
	logic result_valid;
	bsbb_pkg::out_t result;
	logic cfg_write;
	logic [2:0] cfg_index;
	logic [30:0] cfg_data;

	bsbb_pkg::in_t pending_bends[$];
	bsbb_pkg::out_t expected_boxes[$];
	int errors;
	int bends_sent;
	int boxes_seen;
	int idle_pct;
	int idle_cycles;
	logic in_taken;
	logic [30:0] cur_min_extent;
	logic [30:0] cur_long_limit;
	logic [4:0] cur_short_cnt;
	logic [4:0] cur_long_cnt;
	logic [15:0] cur_min_cos;

	bend_swept_bounding_boxes i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] mag16(logic [15:0] v);
		logic signed [63:0] s;
		s = $signed(v);
		return s < 0 ? -s : s;
	endfunction

	function automatic logic [31:0] sat32(logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	// |sin| and |cos| in q16 for an angle in 1/25600 degree
	task automatic abs_sin_cos(input logic [63:0] t_in, output logic [63:0] as,
			output logic [63:0] ac);
		logic [63:0] t, x, x2, a, s, c;
		logic swap;
		t = t_in % HALF_T;
		swap = 1'b0;
		if (t > QUART_T)
			t = HALF_T - t;
		if (t > EIGHTH_T) begin
			t = QUART_T - t;
			swap = 1'b1;
		end
		x = (t * 64'd47975245) >> 16;
		x2 = (x * x) >> 30;
		a = Q30 - x2 / 72;
		a = Q30 - ((x2 * a) >> 30) / 42;
		a = Q30 - ((x2 * a) >> 30) / 20;
		a = Q30 - ((x2 * a) >> 30) / 6;
		s = (x * a) >> 30;
		a = Q30 - x2 / 90;
		a = Q30 - ((x2 * a) >> 30) / 56;
		a = Q30 - ((x2 * a) >> 30) / 30;
		a = Q30 - ((x2 * a) >> 30) / 12;
		c = Q30 - ((x2 * a) >> 30) / 2;
		s = (s + 64'd8192) >> 14;
		c = (c + 64'd8192) >> 14;
		as = swap ? c : s;
		ac = swap ? s : c;
	endtask

	function automatic bsbb_pkg::out_t make_box(bsbb_pkg::in_t b, logic kind,
			logic [63:0] idx, logic [63:0] ext[3], logic last);
		bsbb_pkg::out_t o;
		logic signed [63:0] p[3];
		logic [63:0] e;
		p[0] = $signed(b.pos_x);
		p[1] = $signed(b.pos_y);
		p[2] = $signed(b.pos_z);
		o.bend_tag = b.bend_id;
		o.box_kind = kind;
		o.interval_index = idx[4:0];
		o.last_box = last;
		e = ext[0] < cur_min_extent ? cur_min_extent : ext[0];
		o.min_x = sat32(p[0] - $signed(e));
		o.max_x = sat32(p[0] + $signed(e));
		e = ext[1] < cur_min_extent ? cur_min_extent : ext[1];
		o.min_y = sat32(p[1] - $signed(e));
		o.max_y = sat32(p[1] + $signed(e));
		e = ext[2] < cur_min_extent ? cur_min_extent : ext[2];
		o.min_z = sat32(p[2] - $signed(e));
		o.max_z = sat32(p[2] + $signed(e));
		return o;
	endfunction

	task automatic add_bend(input bsbb_pkg::in_t b);
		pending_bends = {pending_bends, b};
	endtask

	task automatic predict_boxes(input bsbb_pkg::in_t b);
		logic [63:0] n[3], d[3], ext[3];
		logic [63:0] len, ang, cnt, t, as, ac, off;
		len = b.flange_length;
		ang = mag16(b.bend_angle);
		n[0] = mag16(b.norm_x);
		n[1] = mag16(b.norm_y);
		n[2] = mag16(b.norm_z);
		d[0] = mag16(b.dir_x);
		d[1] = mag16(b.dir_y);
		d[2] = mag16(b.dir_z);
		for (int k = 0; k < 3; k++) begin
			off = d[k] > 16384 ? d[k] - 16384 : 16384 - d[k];
			ext[k] = (len * (d[k] + 2 * (n[k] + off))) >> 15;
		end
		expected_boxes = {expected_boxes, make_box(b, 1'b0, 0, ext, 1'b0)};
		cnt = len < cur_long_limit ? cur_short_cnt : cur_long_cnt;
		if (cnt == 0)
			cnt = 1;
		if (cnt > bsbb_pkg::MAX_INTERVALS_DEF)
			cnt = bsbb_pkg::MAX_INTERVALS_DEF;
		for (logic [63:0] i = 0; i <= cnt; i++) begin
			t = (ang * i * 256) / cnt;
			abs_sin_cos(t, as, ac);
			if (ac < cur_min_cos)
				ac = cur_min_cos;
			for (int k = 0; k < 3; k++)
				ext[k] = (len * ((d[k] << 15) + (ac << 13) + as * n[k])) >> 30;
			expected_boxes = {expected_boxes, make_box(b, 1'b1, i, ext, i == cnt)};
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	// request taken at the rising edge
	always @(posedge clk) begin
		in_taken <= arst_n && start && !busy;
		if (arst_n && start && !busy) begin
			predict_boxes(item);
			bends_sent++;
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken || !start) begin
				if (pending_bends.size() > 0 && $urandom_range(99) >= idle_pct) begin
					item <= pending_bends.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			boxes_seen++;
			if (expected_boxes.size() == 0) begin
				report_mismatch("unexpected box", result.bend_tag, 0);
			end else begin
				bsbb_pkg::out_t w;
				w = expected_boxes.pop_front();
				if (result.bend_tag !== w.bend_tag)
					report_mismatch("bend_tag", result.bend_tag, w.bend_tag);
				if (result.box_kind !== w.box_kind)
					report_mismatch("box_kind", result.box_kind, w.box_kind);
				if (result.interval_index !== w.interval_index)
					report_mismatch("interval_index", result.interval_index,
						w.interval_index);
				if (result.min_x !== w.min_x)
					report_mismatch("min_x", result.min_x, w.min_x);
				if (result.min_y !== w.min_y)
					report_mismatch("min_y", result.min_y, w.min_y);
				if (result.min_z !== w.min_z)
					report_mismatch("min_z", result.min_z, w.min_z);
				if (result.max_x !== w.max_x)
					report_mismatch("max_x", result.max_x, w.max_x);
				if (result.max_y !== w.max_y)
					report_mismatch("max_y", result.max_y, w.max_y);
				if (result.max_z !== w.max_z)
					report_mismatch("max_z", result.max_z, w.max_z);
				if (result.last_box !== w.last_box)
					report_mismatch("last_box", result.last_box, w.last_box);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout with %0d boxes outstanding", expected_boxes.size());
				$display("bend_swept_bounding_boxes test failed");
				$finish;
			end
		end
	end

	task automatic write_reg(input bsbb_pkg::reg_idx_t idx, input logic [30:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			bsbb_pkg::REG_MIN_EXTENT: cur_min_extent = val;
			bsbb_pkg::REG_LONG_LIMIT: cur_long_limit = val;
			bsbb_pkg::REG_SHORT_CNT: cur_short_cnt = val[4:0];
			bsbb_pkg::REG_LONG_CNT: cur_long_cnt = val[4:0];
			default: cur_min_cos = val[15:0];
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_bends.size() > 0 || start || expected_boxes.size() > 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_unit();
		case ($urandom_range(3))
			0: return 16'(16384);
			1: return -16'sd16384;
			2: return 16'($urandom);
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	function automatic bsbb_pkg::in_t rand_bend();
		bsbb_pkg::in_t b;
		b.bend_id = $urandom;
		b.pos_x = $urandom_range(9) == 0 ? $urandom : $signed($urandom_range(20000000)) - 10000000;
		b.pos_y = $urandom_range(9) == 0 ? $urandom : $signed($urandom_range(20000000)) - 10000000;
		b.pos_z = $urandom_range(9) == 0 ? $urandom : $signed($urandom_range(20000000)) - 10000000;
		b.norm_x = rand_unit();
		b.norm_y = rand_unit();
		b.norm_z = rand_unit();
		b.dir_x = rand_unit();
		b.dir_y = rand_unit();
		b.dir_z = rand_unit();
		b.flange_length = $urandom_range(7) == 0 ? $urandom : $urandom_range(13107200);
		b.bend_angle = $urandom_range(7) == 0 ? 16'($urandom) :
			16'($signed($urandom_range(36000)) - 18000);
		return b;
	endfunction

	task automatic run_random(input int n, input int pct);
		idle_pct = pct;
		repeat (n) add_bend(rand_bend());
		wait_drained();
	endtask

	initial begin
		bsbb_pkg::in_t b;
		errors = 0;
		bends_sent = 0;
		boxes_seen = 0;
		idle_pct = 0;
		idle_cycles = 0;
		start = 1'b0;
		item = '0;
		cfg_write = 1'b0;
		cfg_index = bsbb_pkg::REG_MIN_EXTENT;
		cfg_data = '0;
		cur_min_extent = bsbb_pkg::MIN_EXTENT_RST;
		cur_long_limit = bsbb_pkg::LONG_LIMIT_RST;
		cur_short_cnt = bsbb_pkg::SHORT_CNT_RST;
		cur_long_cnt = bsbb_pkg::LONG_CNT_RST;
		cur_min_cos = bsbb_pkg::MIN_COS_RST;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes at reset settings
		b = '0;
		add_bend(b);
		b = '1;
		b.flange_length = 31'h7fffffff;
		b.bend_angle = -16'sd32768;
		add_bend(b);
		b.pos_x = 32'h7fffffff;
		b.pos_y = 32'h80000000;
		b.pos_z = 32'h7fffffff;
		b.norm_x = -16'sd32768;
		b.norm_y = 16'sh7fff;
		b.dir_z = -16'sd32768;
		b.bend_angle = 16'sd32767;
		add_bend(b);
		b.bend_angle = 16'sd18000;
		b.flange_length = bsbb_pkg::LONG_LIMIT_RST;
		add_bend(b);
		b.flange_length = bsbb_pkg::LONG_LIMIT_RST - 1;
		b.bend_angle = -16'sd18000;
		add_bend(b);
		b.bend_angle = 16'sd9000;
		b.pos_x = 0;
		b.pos_y = 0;
		b.pos_z = 0;
		add_bend(b);
		wait_drained();

		// zero and maximum counts, zero extent floor, full cos floor
		write_reg(bsbb_pkg::REG_SHORT_CNT, 31'd0);
		write_reg(bsbb_pkg::REG_LONG_CNT, 31'd31);
		write_reg(bsbb_pkg::REG_MIN_EXTENT, 31'd0);
		write_reg(bsbb_pkg::REG_MIN_COS, 31'd65535);
		write_reg(bsbb_pkg::REG_LONG_LIMIT, 31'd0);
		b.bend_angle = 16'sd4500;
		add_bend(b);
		b.flange_length = 0;
		add_bend(b);
		wait_drained();
		write_reg(bsbb_pkg::REG_LONG_LIMIT, 31'h7fffffff);
		write_reg(bsbb_pkg::REG_SHORT_CNT, 31'h7fffffff);
		b.flange_length = 31'h7ffffffe;
		add_bend(b);
		wait_drained();

		// random phases over several register settings
		run_random(50, 0);
		write_reg(bsbb_pkg::REG_MIN_EXTENT, 31'h7fffffff);
		write_reg(bsbb_pkg::REG_MIN_COS, 31'd0);
		write_reg(bsbb_pkg::REG_SHORT_CNT, 31'd1);
		write_reg(bsbb_pkg::REG_LONG_LIMIT, 31'd3276800);
		run_random(40, 59);
		write_reg(bsbb_pkg::REG_MIN_EXTENT, 31'($urandom_range(1000000)));
		write_reg(bsbb_pkg::REG_MIN_COS, 31'($urandom_range(65535)));
		write_reg(bsbb_pkg::REG_SHORT_CNT, 31'($urandom_range(31)));
		write_reg(bsbb_pkg::REG_LONG_CNT, 31'($urandom_range(31)));
		run_random(50, 6);
		write_reg(bsbb_pkg::REG_MIN_EXTENT, bsbb_pkg::MIN_EXTENT_RST);
		write_reg(bsbb_pkg::REG_LONG_LIMIT, bsbb_pkg::LONG_LIMIT_RST);
		write_reg(bsbb_pkg::REG_SHORT_CNT, 31'(bsbb_pkg::SHORT_CNT_RST));
		write_reg(bsbb_pkg::REG_LONG_CNT, 31'(bsbb_pkg::LONG_CNT_RST));
		write_reg(bsbb_pkg::REG_MIN_COS, 31'(bsbb_pkg::MIN_COS_RST));
		run_random(50, 0);

		$display("sent %0d bends and checked %0d boxes over six register settings",
			bends_sent, boxes_seen);
		if (errors == 0)
			$display("bend_swept_bounding_boxes test passed");
		else
			$display("bend_swept_bounding_boxes test failed");
		$finish;
	end
endmodule
